// ----- rtl/packed_2bpp_framebuffer_rotated_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rotated 2bpp framebuffer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKED_2BPP_FRAMEBUFFER_ROTATED_UNIT_MACROS_SVH
`define PACKED_2BPP_FRAMEBUFFER_ROTATED_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define P2FBR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
// Check a property on every clock edge, reset included.
`define P2FBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define P2FBR_ASSERT(lbl, clk, rstn, prop, msg)
`define P2FBR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/p2fbr_pkg.sv -----
// ----------------------------------------------------------------------------
// p2fbr_pkg
// Shared types, command codes and byte tables of the rotated 2bpp framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package p2fbr_pkg;

    // Logical coordinates fit in 10 bits for screens up to 1024 pixels a side.
    localparam int COORD_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] CMD_DRAW  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_HLINE = 3'd3;
    localparam logic [2:0] CMD_VLINE = 3'd4;

    // Register decode on paddr[2].
    localparam logic REG_ROTATION = 1'b0;

    typedef enum logic [2:0] {
        OP_HRUN,
        OP_VRUN,
        OP_READ,
        OP_READ_ZERO,
        OP_FILL
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COUNT_W-1:0] count;
        logic [1:0]         color;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } queue_head_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_PIX_RD,
        ST_PIX_WR
    } back_state_t;

    function automatic logic [7:0] slot_mask(input logic [1:0] slot);
        logic [7:0] m;
        unique case (slot)
            2'd0:    m = 8'h03;
            2'd1:    m = 8'h0C;
            2'd2:    m = 8'h30;
            default: m = 8'hC0;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] fill_pattern(input logic [1:0] color);
        logic [7:0] p;
        unique case (color)
            2'd0:    p = 8'h00;
            2'd1:    p = 8'h55;
            2'd2:    p = 8'hAA;
            default: p = 8'hFF;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/p2fbr_front.sv -----
// ----------------------------------------------------------------------------
// p2fbr_front
// Registers a request, bounds-checks and clips it, and queues the work.
// ----------------------------------------------------------------------------
`default_nettype none

module p2fbr_front import p2fbr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic signed [11:0] s_pos_x,
    input  wire logic signed [11:0] s_pos_y,
    input  wire logic signed [11:0] s_run_length,
    input  wire logic [1:0]         s_pixel_color,
    input  wire logic [1:0]         rotation,
    input  wire logic               clear_done,
    input  wire logic               q_full,
    output logic                    q_push,
    output q_entry_t                q_entry
);

    localparam logic signed [13:0] WIDTH_S  = 14'(SCREEN_WIDTH);
    localparam logic signed [13:0] HEIGHT_S = 14'(SCREEN_HEIGHT);

    logic               in_valid_reg, in_valid_next;
    logic [2:0]         cmd_reg;
    logic signed [11:0] x_reg, y_reg, len_reg;
    logic [1:0]         color_reg;

    logic signed [13:0] x_s, y_s, len_s, lw_s, lh_s;
    logic signed [13:0] start_s, limit_s, sum_s, first_s, cnt_s;
    logic               on_screen, horiz, keep, consume, take;

    always_comb begin
        x_s     = 14'(x_reg);
        y_s     = 14'(y_reg);
        len_s   = 14'(len_reg);
        lw_s    = rotation[0] ? HEIGHT_S : WIDTH_S;
        lh_s    = rotation[0] ? WIDTH_S : HEIGHT_S;
        on_screen = !x_s[13] && !y_s[13] && (x_s < lw_s) && (y_s < lh_s);
        horiz   = (cmd_reg == CMD_HLINE);
        start_s = horiz ? x_s : y_s;
        limit_s = horiz ? lw_s : lh_s;
        sum_s   = start_s + len_s;

        // Clip at the far edge; reverse a negative run and clip it at zero.
        if (sum_s > limit_s) begin
            first_s = start_s;
            cnt_s   = limit_s - start_s;
        end else if (len_s < 14'sd0) begin
            if (sum_s < -14'sd1) begin
                first_s = '0;
                cnt_s   = start_s + 14'sd1;
            end else begin
                first_s = sum_s + 14'sd1;
                cnt_s   = -len_s;
            end
        end else begin
            first_s = start_s;
            cnt_s   = len_s;
        end
    end

    always_comb begin
        q_entry.pos_x = x_s[COORD_W-1:0];
        q_entry.pos_y = y_s[COORD_W-1:0];
        q_entry.count = COUNT_W'(1);
        q_entry.color = color_reg;
        q_entry.op    = OP_HRUN;
        keep          = 1'b0;
        unique case (cmd_reg)
            CMD_DRAW: begin
                keep = on_screen;
            end
            CMD_READ: begin
                keep       = 1'b1;
                q_entry.op = on_screen ? OP_READ : OP_READ_ZERO;
            end
            CMD_FILL: begin
                keep       = 1'b1;
                q_entry.op = OP_FILL;
            end
            CMD_HLINE: begin
                keep          = on_screen && (cnt_s != 14'sd0);
                q_entry.pos_x = first_s[COORD_W-1:0];
                q_entry.count = cnt_s[COUNT_W-1:0];
            end
            CMD_VLINE: begin
                keep          = on_screen && (cnt_s != 14'sd0);
                q_entry.op    = OP_VRUN;
                q_entry.pos_y = first_s[COORD_W-1:0];
                q_entry.count = cnt_s[COUNT_W-1:0];
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Drop requests that do nothing; hold the rest until the queue has room.
    assign consume = in_valid_reg && (!keep || !q_full);
    assign q_push  = in_valid_reg && keep && !q_full;
    assign s_ready = clear_done && (!in_valid_reg || consume);
    assign take    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (consume) begin
            in_valid_next = 1'b0;
        end
        if (take) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg   <= s_cmd;
            x_reg     <= s_pos_x;
            y_reg     <= s_pos_y;
            len_reg   <= s_run_length;
            color_reg <= s_pixel_color;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/p2fbr_queue.sv -----
// ----------------------------------------------------------------------------
// p2fbr_queue
// Short FIFO of classified work between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module p2fbr_queue import p2fbr_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    output logic          full,
    input  wire logic     pop,
    output queue_head_t   head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full       = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/p2fbr_back.sv -----
// ----------------------------------------------------------------------------
// p2fbr_back
// Executes queued work on the packed byte store and drives read results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_2bpp_framebuffer_rotated_unit_macros.svh"

module p2fbr_back import p2fbr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  rotation,
    input  wire queue_head_t head,
    output logic             pop,
    output logic             clear_done,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_read_value
);

    localparam int LINE_BYTES  = (SCREEN_WIDTH + 3) / 4;
    localparam int STORE_BYTES = LINE_BYTES * SCREEN_HEIGHT;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
    localparam logic [ADDR_W-1:0]  ROW_STEP  = ADDR_W'(LINE_BYTES);
    localparam logic [COORD_W-1:0] W_LAST    = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic [COORD_W-1:0] H_LAST    = COORD_W'(SCREEN_HEIGHT - 1);

    logic [7:0] store_mem [STORE_BYTES];
    logic [7:0] mem_rdata_reg;

    back_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  sweep_reg, sweep_next;
    op_t                op_reg, op_next;
    logic [COORD_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         color_reg, color_next;
    logic [7:0]         fill_byte_reg, fill_byte_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [1:0]         slot_reg, slot_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_value_reg, m_value_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;
    logic [COORD_W-1:0] rx_full, ry_full;
    logic [ADDR_W-1:0]  pix_addr;
    logic [7:0]         read_shifted;
    logic               head_is_read, sweep_last, pop_zero;

    assign clear_done   = (state_reg != ST_CLEAR);
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_value_reg;
    assign sweep_last   = (sweep_reg == LAST_ADDR);

    // A read may leave only when the result register is free.
    assign head_is_read = (head.entry.op == OP_READ) || (head.entry.op == OP_READ_ZERO);
    assign pop          = (state_reg == ST_IDLE) && head.valid && (!head_is_read || !m_valid_reg);
    assign pop_zero     = pop && (head.entry.op == OP_READ_ZERO);

    // Turn the logical point into raw coordinates, then into a byte address.
    always_comb begin
        case (rotation)
            2'd1: begin
                rx_full = W_LAST - cur_y_reg;
                ry_full = cur_x_reg;
            end
            2'd2: begin
                rx_full = W_LAST - cur_x_reg;
                ry_full = H_LAST - cur_y_reg;
            end
            2'd3: begin
                rx_full = cur_y_reg;
                ry_full = H_LAST - cur_x_reg;
            end
            default: begin
                rx_full = cur_x_reg;
                ry_full = cur_y_reg;
            end
        endcase
        pix_addr = ADDR_W'(ry_full) * ROW_STEP + ADDR_W'(rx_full >> 2);
    end

    assign read_shifted = mem_rdata_reg >> {slot_reg, 1'b0};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    unique case (head.entry.op)
                        OP_FILL:      state_next = ST_FILL;
                        OP_READ_ZERO: state_next = ST_IDLE;
                        default:      state_next = ST_PIX_RD;
                    endcase
                end
            end
            ST_FILL: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PIX_RD: begin
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR: begin
                if ((op_reg == OP_READ) || (count_reg == COUNT_W'(1))) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_PIX_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        sweep_next     = sweep_reg;
        op_next        = op_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        count_next     = count_reg;
        color_next     = color_reg;
        fill_byte_next = fill_byte_reg;
        addr_next      = addr_reg;
        slot_next      = slot_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_value_next   = m_value_reg;
        mem_we         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = mem_rdata_reg;
        unique case (state_reg) inside
            ST_CLEAR, ST_FILL: begin
                mem_we     = 1'b1;
                mem_addr   = sweep_reg;
                mem_wdata  = (state_reg == ST_CLEAR) ? 8'h00 : fill_byte_reg;
                sweep_next = sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (pop) begin
                    op_next        = head.entry.op;
                    cur_x_next     = head.entry.pos_x;
                    cur_y_next     = head.entry.pos_y;
                    count_next     = head.entry.count;
                    color_next     = head.entry.color;
                    fill_byte_next = fill_pattern(head.entry.color);
                    sweep_next     = '0;
                end
                if (pop_zero) begin
                    m_valid_next = 1'b1;
                    m_value_next = 2'd0;
                end
            end
            ST_PIX_RD: begin
                mem_addr  = pix_addr;
                addr_next = pix_addr;
                slot_next = rx_full[1:0];
            end
            ST_PIX_WR: begin
                if (op_reg == OP_READ) begin
                    m_valid_next = 1'b1;
                    m_value_next = read_shifted[1:0];
                end else begin
                    mem_we     = 1'b1;
                    mem_wdata  = (mem_rdata_reg & ~slot_mask(slot_reg)) |
                                 (8'(color_reg) << {slot_reg, 1'b0});
                    count_next = count_reg - COUNT_W'(1);
                    if (op_reg == OP_HRUN) begin
                        cur_x_next = cur_x_reg + COORD_W'(1);
                    end else begin
                        cur_y_next = cur_y_reg + COORD_W'(1);
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        count_reg     <= count_next;
        color_reg     <= color_next;
        fill_byte_reg <= fill_byte_next;
        addr_reg      <= addr_next;
        slot_reg      <= slot_next;
        m_value_reg   <= m_value_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[mem_addr];
    end

    `P2FBR_ASSERT_ALWAYS(a_reset_clears, aclk,
        !aresetn |=> (state_reg == ST_CLEAR), "reset must start the clearing pass")
    `P2FBR_ASSERT(a_result_source, aclk, aresetn,
        $rose(m_valid_reg) |-> (($past(state_reg) == ST_PIX_WR &&
            $past(op_reg) == OP_READ) || $past(pop_zero)), "result raised without a read")
    `P2FBR_ASSERT(a_count_live, aclk, aresetn,
        (state_reg == ST_PIX_RD || state_reg == ST_PIX_WR) |-> (count_reg != '0),
        "pixel step with empty count")
    `P2FBR_ASSERT(a_addr_range, aclk, aresetn,
        mem_we |-> (mem_addr <= LAST_ADDR), "store write beyond last byte")

endmodule

`default_nettype wire

// ----- rtl/packed_2bpp_framebuffer_rotated_unit.sv -----
// ----------------------------------------------------------------------------
// packed_2bpp_framebuffer_rotated_unit
// Rotated framebuffer of 2-bit pixels packed four to a byte.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to zero, one byte a cycle,
// and holds s_ready low until that pass is done; rotation writes are taken
// at any time. A request then passes through the front register, where it is
// bounds-checked and clipped, and waits in a two-entry queue for the back
// end, which owns the single byte memory. Every pixel goes through a read
// state and then a write state on that memory (read-modify-write of its byte
// for a draw or line; a pixel read only reads), and a fill writes every byte
// once. Only a pixel read gives a result; it sits in an output register so the
// back end keeps working on writes while the result waits for m_ready.
// Unknown commands and draws or lines that draw nothing (off-screen start,
// zero length) are dropped in the front.
`default_nettype none

module packed_2bpp_framebuffer_rotated_unit import p2fbr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // request channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic signed [11:0] s_pos_x,
    input  wire logic signed [11:0] s_pos_y,
    input  wire logic signed [11:0] s_run_length,
    input  wire logic [1:0]         s_pixel_color,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_read_value,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [1:0]  rotation_reg, rotation_next;
    logic        clear_done;
    logic        q_push, q_full, q_pop;
    q_entry_t    q_entry;
    queue_head_t q_head;

    // Configuration: one register, rotation, at byte address 0.
    assign pready = 1'b1;

    always_comb begin
        rotation_next = rotation_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_ROTATION)) begin
            rotation_next = pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ROTATION) begin
            prdata = {30'b0, rotation_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg <= 2'd0;
        end else begin
            rotation_reg <= rotation_next;
        end
    end

    // Front: register, classify and clip each request.
    p2fbr_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_run_length  (s_run_length),
        .s_pixel_color (s_pixel_color),
        .rotation      (rotation_reg),
        .clear_done    (clear_done),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    // Queue: decouple the front from memory work.
    p2fbr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Back: clear, fill, pixel read-modify-write and read results.
    p2fbr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rotation     (rotation_reg),
        .head         (q_head),
        .pop          (q_pop),
        .clear_done   (clear_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value)
    );

endmodule

`default_nettype wire

// ----- bench/packed_2bpp_framebuffer_rotated_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated 2bpp framebuffer - block-level test
// Streams pixel, line, fill and read requests into the framebuffer under every
// rotation and checks each pixel read against a cycle-free pixel map kept here.
// ----------------------------------------------------------------------------
module packed_2bpp_framebuffer_rotated_unit_test;
    import p2fbr_pkg::*;

    localparam int SCREEN_W    = 128;
    localparam int SCREEN_H    = 128;
    localparam int STORE_BYTES = ((SCREEN_W + 3) / 4) * SCREEN_H;

    // A fill writes one byte per cycle. Up to four requests can be in flight
    // after the last one is taken (front register, two queue entries and the
    // one the back end works on), so four back-to-back fills bound the busy time.
    localparam int DRAIN_CYCLES = 4 * (STORE_BYTES + 2) + 64;
    localparam int CYCLE_LIMIT  = 8_000_000;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 166;
    localparam int STEADY_PHASE    = 3;
    localparam int STALL_PERCENT   = 16;

    // Command codes that the block has no meaning for.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // Rotation register sits at byte address 0.
    localparam logic [2:0] ROTATION_ADDR = {REG_ROTATION, 2'b00};

    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [11:0] run_length;
        logic [1:0]  color;
    } draw_request_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O
    // ------------------------------------------------------------------------
    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [2:0]         s_cmd         = '0;
    logic signed [11:0] s_pos_x       = '0;
    logic signed [11:0] s_pos_y       = '0;
    logic signed [11:0] s_run_length  = '0;
    logic [1:0]         s_pixel_color = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [1:0]         m_read_value;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [2:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    always #2 aclk = ~aclk;

    packed_2bpp_framebuffer_rotated_unit #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_run_length (s_run_length),
        .s_pixel_color(s_pixel_color),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------------
    // Pixel map: raw screen contents, one 2-bit entry per pixel, plus the
    // rotation the block is set to. Indexed [raw y][raw x].
    // ------------------------------------------------------------------------
    logic [1:0] frame_pix [SCREEN_H][SCREEN_W];
    logic [1:0] rotation_cfg = 2'd0;
    logic [1:0] read_values_due [$];

    draw_request_t pending_requests [$];
    int  issued_count   = 0;
    int  accepted_count = 0;
    int  error_count    = 0;
    int  cycle_count    = 0;
    bit  req_taken      = 1'b0;
    bit  steady_phase   = 1'b0;

    initial begin
        for (int r = 0; r < SCREEN_H; r++)
            for (int c = 0; c < SCREEN_W; c++)
                frame_pix[r][c] = 2'd0;
    end

    function automatic int logical_w();
        return rotation_cfg[0] ? SCREEN_H : SCREEN_W;
    endfunction

    function automatic int logical_h();
        return rotation_cfg[0] ? SCREEN_W : SCREEN_H;
    endfunction

    // Turn a logical point into raw screen coordinates.
    task automatic map_to_raw(input int x, input int y, output int rx, output int ry);
        case (rotation_cfg)
            2'd1: begin
                rx = SCREEN_W - 1 - y;
                ry = x;
            end
            2'd2: begin
                rx = SCREEN_W - 1 - x;
                ry = SCREEN_H - 1 - y;
            end
            2'd3: begin
                rx = y;
                ry = SCREEN_H - 1 - x;
            end
            default: begin
                rx = x;
                ry = y;
            end
        endcase
    endtask

    task automatic plot_pixel(input int x, input int y, input logic [1:0] color);
        int rx, ry;
        map_to_raw(x, y, rx, ry);
        if (rx >= 0 && ry >= 0 && rx < SCREEN_W && ry < SCREEN_H)
            frame_pix[ry][rx] = color;
    endtask

    task automatic sample_pixel(input int x, input int y, output logic [1:0] value);
        int rx, ry;
        map_to_raw(x, y, rx, ry);
        if (rx >= 0 && ry >= 0 && rx < SCREEN_W && ry < SCREEN_H)
            value = frame_pix[ry][rx];
        else
            value = 2'd0;
    endtask

    // Clip a run along one logical axis, then plot it pixel by pixel.
    task automatic draw_run(input int x, input int y, input int len, input bit horiz,
                            input logic [1:0] color);
        int lw, lh, start, limit;
        lw    = logical_w();
        lh    = logical_h();
        start = horiz ? x : y;
        limit = horiz ? lw : lh;
        if (x < 0 || y < 0 || x >= lw || y >= lh)
            return;
        if (start + len > limit) begin
            len = limit - start;
        end else if (len < 0) begin
            len   = -len;
            start = start - (len - 1);
            if (start < 0) begin
                len   = len + start;
                start = 0;
            end
        end
        for (int i = 0; i < len; i++) begin
            if (horiz)
                plot_pixel(start + i, y, color);
            else
                plot_pixel(x, start + i, color);
        end
    endtask

    // Apply one accepted request to the pixel map; queue a read's answer.
    task automatic render_request(input draw_request_t req);
        int x, y, len;
        logic [1:0] value;
        x   = int'($signed(req.pos_x));
        y   = int'($signed(req.pos_y));
        len = int'($signed(req.run_length));
        case (req.cmd)
            CMD_DRAW: begin
                if (x >= 0 && y >= 0 && x < logical_w() && y < logical_h())
                    plot_pixel(x, y, req.color);
            end
            CMD_READ: begin
                sample_pixel(x, y, value);
                read_values_due.push_back(value);
            end
            CMD_FILL: begin
                for (int r = 0; r < SCREEN_H; r++)
                    for (int c = 0; c < SCREEN_W; c++)
                        frame_pix[r][c] = req.color;
            end
            CMD_HLINE: draw_run(x, y, len, 1'b1, req.color);
            CMD_VLINE: draw_run(x, y, len, 1'b0, req.color);
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Request driver: update at the falling edge. Hold the current request until
    // it is taken, then advance to the next one or, outside the steady phase, idle at random.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        draw_request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (pending_requests.size() != 0 &&
                (steady_phase || $urandom_range(0, 99) >= STALL_PERCENT)) begin
                nxt = pending_requests.pop_front();
                s_valid       <= 1'b1;
                s_cmd         <= nxt.cmd;
                s_pos_x       <= nxt.pos_x;
                s_pos_y       <= nxt.pos_y;
                s_run_length  <= nxt.run_length;
                s_pixel_color <= nxt.color;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, except in the steady phase.
    always @(negedge aclk) begin
        m_ready <= steady_phase || ($urandom_range(0, 99) >= STALL_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge. Feed every accepted request into the
    // pixel map, and compare every delivered read with the oldest one due.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [1:0] due;
        req_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            accepted_count <= accepted_count + 1;
            render_request('{s_cmd, s_pos_x, s_pos_y, s_run_length, s_pixel_color});
        end
        if (aresetn && m_valid && m_ready) begin
            if (read_values_due.size() == 0) begin
                $error("read_value: unexpected result, expected none, got %0d",
                       m_read_value);
                error_count++;
            end else begin
                due = read_values_due.pop_front();
                if (m_read_value !== due) begin
                    $error("read_value mismatch: expected %0d, got %0d", due, m_read_value);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: bounds the whole run, the post-reset clearing sweep included.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_request(input logic [2:0] cmd, input int x, input int y,
                                 input int len, input logic [1:0] color);
        draw_request_t req;
        req.cmd        = cmd;
        req.pos_x      = x[11:0];
        req.pos_y      = y[11:0];
        req.run_length = len[11:0];
        req.color      = color;
        pending_requests.push_back(req);
        issued_count++;
    endtask

    // Two-phase register write: setup, then access; the write lands on the
    // rising edge inside the access cycle.
    task automatic write_rotation(input logic [1:0] turns);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROTATION_ADDR;
        pwdata  <= {30'd0, turns};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rotation_cfg = turns;
    endtask

    // Wait until every request is in and every read is back, then let any
    // trailing line or fill finish before touching the register again.
    task automatic wait_drained();
        while (accepted_count != issued_count || pending_requests.size() != 0)
            @(negedge aclk);
        while (read_values_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [1:0] turn_plan [PHASES];
        int roll, x, y, len, lw, lh, last_x, last_y, fills_left;
        logic [1:0] color;

        turn_plan = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3, 2'd1};
        last_x = 0;
        last_y = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Rotation writes are taken even while the clearing sweep runs.
        write_rotation(turn_plan[0]);
        @(posedge aclk);

        // Directed: cleared screen, corners, off-screen points, clipped and
        // reversed lines, empty lines, unknown commands, fills in three colors.
        queue_request(CMD_READ,  0, 0, 0, 2'd0);
        queue_request(CMD_DRAW,  0, 0, 0, 2'd3);
        queue_request(CMD_READ,  0, 0, 0, 2'd0);
        queue_request(CMD_DRAW,  SCREEN_W - 1, SCREEN_H - 1, 0, 2'd2);
        queue_request(CMD_READ,  SCREEN_W - 1, SCREEN_H - 1, 0, 2'd0);
        queue_request(CMD_DRAW,  -1, 5, 0, 2'd3);
        queue_request(CMD_DRAW,  SCREEN_W, 0, 0, 2'd3);
        queue_request(CMD_READ,  -2048, 2047, 0, 2'd3);
        queue_request(CMD_READ,  2047, -2048, 0, 2'd3);
        queue_request(CMD_HLINE, SCREEN_W - 8, 10, 2047, 2'd1);
        queue_request(CMD_READ,  SCREEN_W - 1, 10, 0, 2'd0);
        queue_request(CMD_HLINE, 5, 20, -2048, 2'd3);
        queue_request(CMD_READ,  0, 20, 0, 2'd0);
        queue_request(CMD_VLINE, 7, 0, 0, 2'd3);
        queue_request(CMD_VLINE, 7, SCREEN_H - 1, -3, 2'd2);
        queue_request(CMD_VLINE, -1, 0, 10, 2'd3);
        queue_request(CMD_UNUSED_LO, -1, -1, -1, 2'd3);
        queue_request(CMD_UNUSED_HI, 0, 0, 0, 2'd0);
        queue_request(CMD_FILL,  0, 0, 0, 2'd1);
        queue_request(CMD_READ,  64, 64, 0, 2'd0);
        queue_request(CMD_FILL,  0, 0, 0, 2'd3);
        queue_request(CMD_READ,  1, 1, 0, 2'd0);
        queue_request(CMD_FILL,  0, 0, 0, 2'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                wait_drained();
                write_rotation(turn_plan[phase]);
                @(posedge aclk);
            end
            steady_phase = (phase == STEADY_PHASE);
            fills_left   = 1;
            lw = logical_w();
            lh = logical_h();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll  = $urandom_range(0, 199);
                color = 2'($urandom_range(0, 3));
                // Mostly on-screen points, with edges and the full field range
                // mixed in.
                if ($urandom_range(0, 99) < 8) begin
                    x = int'($urandom_range(0, 4095)) - 2048;
                    y = int'($urandom_range(0, 4095)) - 2048;
                end else begin
                    x = $urandom_range(0, lw - 1);
                    y = $urandom_range(0, lh - 1);
                    if ($urandom_range(0, 9) == 0)
                        x = ($urandom_range(0, 1) != 0) ? lw - 1 : 0;
                    if ($urandom_range(0, 9) == 0)
                        y = ($urandom_range(0, 1) != 0) ? lh - 1 : 0;
                end
                if ($urandom_range(0, 99) < 10)
                    len = int'($urandom_range(0, 4095)) - 2048;
                else
                    len = int'($urandom_range(0, 80)) - 40;

                if (roll < 70) begin
                    queue_request(CMD_DRAW, x, y, len, color);
                    last_x = x;
                    last_y = y;
                end else if (roll < 140) begin
                    // Half of these reads revisit the last point touched.
                    if ($urandom_range(0, 1) != 0) begin
                        x = last_x;
                        y = last_y;
                    end
                    queue_request(CMD_READ, x, y, len, color);
                end else if (roll < 165) begin
                    queue_request(CMD_HLINE, x, y, len, color);
                    last_x = x;
                    last_y = y;
                end else if (roll < 190) begin
                    queue_request(CMD_VLINE, x, y, len, color);
                    last_x = x;
                    last_y = y;
                end else if (roll < 196) begin
                    queue_request(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                                  x, y, len, color);
                end else if (fills_left != 0) begin
                    queue_request(CMD_FILL, x, y, len, color);
                    fills_left--;
                end else begin
                    queue_request(CMD_READ, x, y, len, color);
                end
            end
        end

        wait_drained();
        if (error_count == 0 && read_values_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/p2fbr_pkg.sv
rtl/p2fbr_front.sv
rtl/p2fbr_queue.sv
rtl/p2fbr_back.sv
rtl/packed_2bpp_framebuffer_rotated_unit.sv
bench/packed_2bpp_framebuffer_rotated_unit_test.sv
